/* sv/cept_pkg.sv */
// Shared types, constants and the cosine table function for the pose tweener.
`timescale 1ns / 1ps

package cept_pkg;

    // Number of pose components per joint: ang x, y, z then pos x, y, z.
    localparam int NCOMP = 6;

    // Component codes.
    localparam logic [2:0] COMP_ANG_X = 3'd0;
    localparam logic [2:0] COMP_ANG_Y = 3'd1;
    localparam logic [2:0] COMP_ANG_Z = 3'd2;
    localparam logic [2:0] COMP_POS_X = 3'd3;
    localparam logic [2:0] COMP_POS_Y = 3'd4;
    localparam logic [2:0] COMP_POS_Z = 3'd5;

    // Request types.
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // Pi in Q30 and one in Q30 for the table series.
    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;

    typedef struct packed {
        logic              req_type;
        logic [1:0]        bank;
        logic [3:0]        joint;
        logic signed [31:0] target_ang_x;
        logic signed [31:0] target_ang_y;
        logic signed [31:0] target_ang_z;
        logic signed [31:0] target_pos_x;
        logic signed [31:0] target_pos_y;
        logic signed [31:0] target_pos_z;
        logic [15:0]       move_frames;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        out_bank;
        logic [3:0]        out_joint;
        logic signed [31:0] ang_x;
        logic signed [31:0] ang_y;
        logic signed [31:0] ang_z;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic              moving;
        logic              last;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic clr_c;
        logic inc_c;
        logic clr_j;
        logic inc_j;
        logic wr_start;
        logic wr_ed_new;
        logic snap;
        logic div_go;
        logic div_fin;
        logic mul;
        logic wr_ease;
        logic wr_snapc;
        logic cap_cur;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_tick;
        logic bank_ok;
        logic joint_ok;
        logic act;
        logic snap;
        logic div_done;
        logic c_last;
        logic j_last;
    } t_stat;

    // Target component of an input item selected by component code.
    function automatic logic [31:0] item_comp(input t_in_item it, input logic [2:0] c);
        logic [31:0] v;
        case (c)
            COMP_ANG_X: v = it.target_ang_x;
            COMP_ANG_Y: v = it.target_ang_y;
            COMP_ANG_Z: v = it.target_ang_z;
            COMP_POS_X: v = it.target_pos_x;
            COMP_POS_Y: v = it.target_pos_y;
            default:    v = it.target_pos_z;
        endcase
        return v;
    endfunction

    // Cosine magnitude in Q16.16 of a Q30 angle in [0, pi/2], nine series terms.
    function automatic logic [16:0] cos_mag(input logic [63:0] theta);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        prod;
        logic signed [63:0] sum;
        logic signed [63:0] mag;
        x2   = (theta * theta) >> 30;
        sum  = $signed(ONE_Q30);
        term = ONE_Q30;
        for (int n = 1; n <= 8; n++) begin
            prod = (term * x2) >> 30;
            case (n)
                1:       term = prod / 2;
                2:       term = prod / 12;
                3:       term = prod / 30;
                4:       term = prod / 56;
                5:       term = prod / 90;
                6:       term = prod / 132;
                7:       term = prod / 182;
                default: term = prod / 240;
            endcase
            if (n % 2 == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        mag = (sum + 64'sd8192) >>> 14;
        if (mag > 64'sd65536) begin
            mag = 64'sd65536;
        end
        return mag[16:0];
    endfunction

endpackage

/* sv/cept_ram.sv */
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module cept_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 180
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/cept_div.sv */
// Restoring divider producing one quotient bit per cycle.
`timescale 1ns / 1ps

module cept_div #(
    parameter int NW = 26,
    parameter int DW = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_q;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   rem_sh;
    logic [DW:0]   rem_nx;
    logic          fits;

    // One trial subtraction per cycle.
    always_comb begin
        rem_sh = {r_rem, r_q[NW-1]};
        fits   = rem_sh >= {1'b0, r_den};
        rem_nx = fits ? (rem_sh - {1'b0, r_den}) : rem_sh;
    end

    // Step control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Quotient and remainder shift registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[NW-2:0], fits};
            r_rem <= rem_nx[DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

/* sv/cept_ctrl.sv */
// Controller state machine sequencing start and tick items.
`timescale 1ns / 1ps

module cept_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output cept_pkg::t_cmd o_cmd,
    input  cept_pkg::t_stat i_stat
);

    import cept_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC  = 4'd1;
    localparam logic [3:0] S_SRD  = 4'd2;
    localparam logic [3:0] S_SWR  = 4'd3;
    localparam logic [3:0] S_JCHK = 4'd4;
    localparam logic [3:0] S_ED   = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_ERD  = 4'd7;
    localparam logic [3:0] S_EMUL = 4'd8;
    localparam logic [3:0] S_EWR  = 4'd9;
    localparam logic [3:0] S_TRD  = 4'd10;
    localparam logic [3:0] S_TWR  = 4'd11;
    localparam logic [3:0] S_CRD  = 4'd12;
    localparam logic [3:0] S_CCAP = 4'd13;
    localparam logic [3:0] S_OUT  = 4'd14;

    logic [3:0] r_state;
    logic [3:0] n_state;
    t_cmd       cmd;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_DEC;
                end
            end
            S_DEC: begin
                cmd.clr_c = 1'b1;
                cmd.clr_j = 1'b1;
                if (!i_stat.bank_ok) begin
                    n_state = S_IDLE;
                end else if (i_stat.is_tick) begin
                    n_state = S_JCHK;
                end else begin
                    n_state = i_stat.joint_ok ? S_SRD : S_IDLE;
                end
            end
            S_SRD: n_state = S_SWR;
            S_SWR: begin
                cmd.wr_start = 1'b1;
                if (i_stat.c_last) begin
                    cmd.wr_ed_new = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    cmd.inc_c = 1'b1;
                    n_state   = S_SRD;
                end
            end
            S_JCHK: begin
                cmd.clr_c = 1'b1;
                n_state   = i_stat.act ? S_ED : S_CRD;
            end
            S_ED: begin
                if (i_stat.snap) begin
                    cmd.snap = 1'b1;
                    n_state  = S_TRD;
                end else begin
                    cmd.div_go = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    cmd.div_fin = 1'b1;
                    n_state     = S_ERD;
                end
            end
            S_ERD: n_state = S_EMUL;
            S_EMUL: begin
                cmd.mul = 1'b1;
                n_state = S_EWR;
            end
            S_EWR: begin
                cmd.wr_ease = 1'b1;
                if (i_stat.c_last) begin
                    n_state = S_OUT;
                end else begin
                    cmd.inc_c = 1'b1;
                    n_state   = S_ERD;
                end
            end
            S_TRD: n_state = S_TWR;
            S_TWR: begin
                cmd.wr_snapc = 1'b1;
                if (i_stat.c_last) begin
                    n_state = S_OUT;
                end else begin
                    cmd.inc_c = 1'b1;
                    n_state   = S_TRD;
                end
            end
            S_CRD: n_state = S_CCAP;
            S_CCAP: begin
                cmd.cap_cur = 1'b1;
                if (i_stat.c_last) begin
                    n_state = S_OUT;
                end else begin
                    cmd.inc_c = 1'b1;
                    n_state   = S_CRD;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    if (i_stat.j_last) begin
                        n_state = S_IDLE;
                    end else begin
                        cmd.inc_j = 1'b1;
                        n_state   = S_JCHK;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd       = cmd;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    // The divider only finishes while the controller waits for it.
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.div_done |-> r_state == S_DIV)
        else $error("divider finished outside the divide wait");

    // A result is only offered once all six components are in place.
    a_out_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_stat.c_last))
        else $error("item offered before its last component");

    // A waiting result stays offered until it is taken.
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !i_out_ready) |=> r_state == S_OUT)
        else $error("result withdrawn before it was taken");

endmodule

/* sv/cept_dp.sv */
// Datapath: pose memories, joint flags, divider, cosine table and easing multiplier.
`timescale 1ns / 1ps

module cept_dp #(
    parameter int BANKS       = 3,
    parameter int JOINTS      = 10,
    parameter int COS_ENTRIES = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cept_pkg::t_in_item  i_item,
    input  cept_pkg::t_cmd      i_cmd,
    output cept_pkg::t_stat     o_stat,
    output cept_pkg::t_out_item o_item
);

    import cept_pkg::*;

    localparam int NSLOT = BANKS * JOINTS;
    localparam int SW    = (NSLOT > 1) ? $clog2(NSLOT) : 1;
    localparam int JW    = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam int DEPTH = NSLOT * NCOMP;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = 18 + $clog2(COS_ENTRIES);
    localparam int DW    = 17;
    localparam int IW    = $clog2(COS_ENTRIES + 1);

    t_in_item            r_item;
    logic [2:0]          r_c;
    logic [JW-1:0]       r_j;
    logic [NSLOT-1:0]    r_active;
    logic [NSLOT-1:0]    r_cur_vld;
    logic [15:0]         r_el;
    logic [15:0]         r_du;
    logic [17:0]         r_w;
    logic signed [51:0]  r_p;
    logic [31:0]         r_s;
    logic [31:0]         r_out [NCOMP];

    logic                is_tick;
    logic [SW-1:0]       slot;
    logic [AW-1:0]       addr;
    logic [31:0]         cur_rd;
    logic [31:0]         st_rd;
    logic [31:0]         tgt_rd;
    logic [31:0]         ed_rd;
    logic [31:0]         cur_wd;
    logic [31:0]         st_wd;
    logic [31:0]         ed_wd;
    logic                cur_we;
    logic                ed_we;
    logic [16:0]         el17;
    logic [15:0]         el16;
    logic [NW-1:0]       num;
    logic                div_done;
    logic [NW-1:0]       quo;
    logic [IW-1:0]       idx;
    logic signed [17:0]  w_cos [COS_ENTRIES+1];
    logic signed [32:0]  diff;
    logic signed [51:0]  q52;
    logic [31:0]         ease;
    logic [31:0]         cur_val;

    // Cosine table in Q16.16, built at elaboration.
    for (genvar k = 0; k <= COS_ENTRIES; k++) begin : g_cos
        localparam bit          NEG   = (2 * k > COS_ENTRIES);
        localparam logic [63:0] KK    = NEG ? 64'(COS_ENTRIES - k) : 64'(k);
        localparam logic [63:0] THETA = (PI_Q30 * KK) / COS_ENTRIES;
        localparam logic [16:0] MAG   = cos_mag(THETA);
        assign w_cos[k] = NEG ? -$signed({1'b0, MAG}) : $signed({1'b0, MAG});
    end

    // Slot and memory address of the joint and component in work.
    always_comb begin
        is_tick = (r_item.req_type == REQ_TICK);
        slot    = SW'(32'(r_item.bank) * 32'(JOINTS)
                  + (is_tick ? 32'(r_j) : 32'(r_item.joint)));
        addr    = AW'(32'(slot) * 32'(NCOMP) + 32'(r_c));
    end

    // Elapsed count after this tick and the index division operands.
    always_comb begin
        el17 = {1'b0, ed_rd[31:16]} + 17'd1;
        el16 = el17[15:0];
        num  = (NW'({el16, 1'b0}) * NW'(COS_ENTRIES)) + NW'(ed_rd[15:0]);
        idx  = (quo > NW'(COS_ENTRIES)) ? IW'(COS_ENTRIES) : IW'(quo);
    end

    // Easing arithmetic.
    always_comb begin
        diff    = $signed({tgt_rd[31], tgt_rd}) - $signed({st_rd[31], st_rd});
        q52     = (r_p + 52'sd65536) >>> 17;
        ease    = r_s + q52[31:0];
        cur_val = r_cur_vld[slot] ? cur_rd : 32'd0;
    end

    // Memory write data.
    always_comb begin
        cur_we = i_cmd.wr_ease | i_cmd.wr_snapc;
        cur_wd = i_cmd.wr_ease ? ease : tgt_rd;
        st_wd  = cur_val;
        ed_we  = i_cmd.wr_ed_new | i_cmd.snap | i_cmd.div_fin;
        if (i_cmd.wr_ed_new) begin
            ed_wd = {16'd0, r_item.move_frames};
        end else if (i_cmd.snap) begin
            ed_wd = {ed_rd[15:0], ed_rd[15:0]};
        end else begin
            ed_wd = {r_el, r_du};
        end
    end

    cept_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_cur (
        .i_clk(i_clk), .i_we(cur_we), .i_waddr(addr), .i_wdata(cur_wd),
        .i_raddr(addr), .o_rdata(cur_rd)
    );

    cept_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_start (
        .i_clk(i_clk), .i_we(i_cmd.wr_start), .i_waddr(addr), .i_wdata(st_wd),
        .i_raddr(addr), .o_rdata(st_rd)
    );

    cept_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_target (
        .i_clk(i_clk), .i_we(i_cmd.wr_start), .i_waddr(addr),
        .i_wdata(item_comp(r_item, r_c)), .i_raddr(addr), .o_rdata(tgt_rd)
    );

    cept_ram #(.WIDTH(32), .DEPTH(NSLOT)) u_ed (
        .i_clk(i_clk), .i_we(ed_we), .i_waddr(slot), .i_wdata(ed_wd),
        .i_raddr(slot), .o_rdata(ed_rd)
    );

    cept_div #(.NW(NW), .DW(DW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_go),
        .i_num(num), .i_den({ed_rd[15:0], 1'b0}), .o_done(div_done), .o_quo(quo)
    );

    // Joint flags (moving, current pose written since reset) and the component and joint counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= '0;
            r_cur_vld <= '0;
            r_c       <= '0;
            r_j       <= '0;
        end else begin
            if (i_cmd.wr_ed_new) begin
                r_active[slot] <= 1'b1;
            end
            if (i_cmd.snap) begin
                r_active[slot] <= 1'b0;
            end
            if (cur_we) begin
                r_cur_vld[slot] <= 1'b1;
            end
            if (i_cmd.clr_c) begin
                r_c <= '0;
            end else if (i_cmd.inc_c) begin
                r_c <= r_c + 3'd1;
            end
            if (i_cmd.clr_j) begin
                r_j <= '0;
            end else if (i_cmd.inc_j) begin
                r_j <= r_j + 1'b1;
            end
        end
    end

    // Item, easing and output registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.div_go) begin
            r_el <= el16;
            r_du <= ed_rd[15:0];
        end
        if (i_cmd.div_fin) begin
            r_w <= 18'(19'sd65536 - 19'(w_cos[idx]));
        end
        if (i_cmd.mul) begin
            r_p <= diff * $signed({1'b0, r_w});
            r_s <= st_rd;
        end
        if (i_cmd.wr_ease) begin
            r_out[r_c] <= ease;
        end else if (i_cmd.wr_snapc) begin
            r_out[r_c] <= tgt_rd;
        end else if (i_cmd.cap_cur) begin
            r_out[r_c] <= cur_val;
        end
    end

    // Status to the controller.
    always_comb begin
        o_stat.is_tick  = is_tick;
        o_stat.bank_ok  = 32'(r_item.bank) < 32'(BANKS);
        o_stat.joint_ok = 32'(r_item.joint) < 32'(JOINTS);
        o_stat.act      = r_active[slot];
        o_stat.snap     = el17 >= {1'b0, ed_rd[15:0]};
        o_stat.div_done = div_done;
        o_stat.c_last   = (r_c == 3'(NCOMP - 1));
        o_stat.j_last   = (r_j == JW'(JOINTS - 1));
    end

    // Result item.
    always_comb begin
        o_item.out_bank  = r_item.bank;
        o_item.out_joint = 4'(r_j);
        o_item.ang_x     = r_out[COMP_ANG_X];
        o_item.ang_y     = r_out[COMP_ANG_Y];
        o_item.ang_z     = r_out[COMP_ANG_Z];
        o_item.pos_x     = r_out[COMP_POS_X];
        o_item.pos_y     = r_out[COMP_POS_Y];
        o_item.pos_z     = r_out[COMP_POS_Z];
        o_item.moving    = r_active[slot];
        o_item.last      = (r_j == JW'(JOINTS - 1));
    end

endmodule

/* sv/cosine_eased_pose_tweener.sv */
// Top level of the cosine-eased pose tweener.
// A start item is accepted and decoded, then each component of the current pose is read and stored as the start.
// A tick item is accepted and decoded, then walks the bank's joints one at a time: an idle joint
// copies its current pose, one that reaches its target snaps to it, and an easing joint runs
// the bit-serial index divider and the shared multiplier; each result waits out receiver stalls.
// Reset is synchronous, active low; the pose table reads as zero and no joint moves after it.
`timescale 1ns / 1ps

module cosine_eased_pose_tweener #(
    parameter int BANKS       = 3,
    parameter int JOINTS      = 10,
    parameter int COS_ENTRIES = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  cept_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output cept_pkg::t_out_item o_out
);

    import cept_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequencer.
    cept_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_cmd(cmd), .i_stat(stat)
    );

    // Storage and arithmetic.
    cept_dp #(.BANKS(BANKS), .JOINTS(JOINTS), .COS_ENTRIES(COS_ENTRIES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(i_in), .i_cmd(cmd),
        .o_stat(stat), .o_item(o_out)
    );

endmodule

/* dv/cept_pose_checker.sv */
// Checker for the pose tweener: predicts tick results and compares each output item.
`timescale 1ns / 1ps

module cept_pose_checker #(
    parameter int BANKS       = 3,
    parameter int JOINTS      = 10,
    parameter int COS_ENTRIES = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  cept_pkg::t_in_item  i_in,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  cept_pkg::t_out_item i_out,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_results_seen
);
    import cept_pkg::*;

    localparam int SLOTS = BANKS * JOINTS;

    logic signed [31:0] cur_pose   [SLOTS][NCOMP];
    logic signed [31:0] from_pose  [SLOTS][NCOMP];
    logic signed [31:0] goal_pose  [SLOTS][NCOMP];
    logic [15:0]        frames_done[SLOTS];
    logic [15:0]        frames_total[SLOTS];
    logic               in_motion  [SLOTS];
    logic signed [31:0] cos_table  [COS_ENTRIES + 1];
    t_out_item          expected_poses[$];

    // Cosine of pi*k/COS_ENTRIES in Q16.16, built from a Q30 series.
    function automatic logic signed [31:0] cosine_at(input int k);
        longint unsigned kk, theta, x2, term;
        longint          sum, mag;
        bit              neg;
        kk  = k;
        neg = 0;
        if (2 * k > COS_ENTRIES) begin
            kk  = COS_ENTRIES - k;
            neg = 1;
        end
        theta = (64'd3373259426 * kk) / COS_ENTRIES;
        x2    = (theta * theta) >> 30;
        sum   = 64'd1073741824;
        term  = 64'd1073741824;
        for (int n = 1; n <= 8; n++) begin
            term = ((term * x2) >> 30) / ((2 * n - 1) * (2 * n));
            if (n % 2 == 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
        end
        if (sum < 0) sum = 0;
        mag = (sum + 8192) >>> 14;
        if (mag > 65536) mag = 65536;
        return 32'(neg ? -mag : mag);
    endfunction

    // Eased component: start + floor(((target - start) * w + 65536) / 131072).
    function automatic logic signed [31:0] eased(input longint s, input longint t,
                                                 input longint w);
        longint p;
        p = (t - s) * w + 65536;
        return 32'(s + (p >>> 17));
    endfunction

    // Update the predicted state for one accepted item.
    task automatic predict_item(input t_in_item it);
        int        slot;
        int        el, du;
        longint    idx, w;
        t_out_item r;
        logic signed [31:0] tgt[NCOMP];
        if (it.bank >= BANKS) return;
        if (it.req_type == REQ_START) begin
            if (it.joint >= JOINTS) return;
            slot = it.bank * JOINTS + it.joint;
            tgt = '{it.target_ang_x, it.target_ang_y, it.target_ang_z,
                    it.target_pos_x, it.target_pos_y, it.target_pos_z};
            for (int c = 0; c < NCOMP; c++) begin
                from_pose[slot][c] = cur_pose[slot][c];
                goal_pose[slot][c] = tgt[c];
            end
            frames_done[slot]  = 0;
            frames_total[slot] = it.move_frames;
            in_motion[slot]    = 1;
            return;
        end
        for (int j = 0; j < JOINTS; j++) begin
            slot = it.bank * JOINTS + j;
            if (in_motion[slot]) begin
                el = frames_done[slot] + 1;
                du = frames_total[slot];
                if (el >= du) begin
                    for (int c = 0; c < NCOMP; c++) cur_pose[slot][c] = goal_pose[slot][c];
                    in_motion[slot] = 0;
                    el = du;
                end else begin
                    idx = (2 * longint'(el) * COS_ENTRIES + du) / (2 * longint'(du));
                    if (idx > COS_ENTRIES) idx = COS_ENTRIES;
                    w = 65536 - longint'(cos_table[idx]);
                    for (int c = 0; c < NCOMP; c++)
                        cur_pose[slot][c] = eased(from_pose[slot][c], goal_pose[slot][c], w);
                end
                frames_done[slot] = el[15:0];
            end
            r.out_bank  = it.bank;
            r.out_joint = j[3:0];
            r.ang_x     = cur_pose[slot][0];
            r.ang_y     = cur_pose[slot][1];
            r.ang_z     = cur_pose[slot][2];
            r.pos_x     = cur_pose[slot][3];
            r.pos_y     = cur_pose[slot][4];
            r.pos_z     = cur_pose[slot][5];
            r.moving    = in_motion[slot];
            r.last      = (j == JOINTS - 1);
            expected_poses.push_back(r);
        end
    endtask

    // Compare one field and count a mismatch.
    task automatic compare_field(input string name, input longint exp_v, input longint act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    initial begin
        for (int k = 0; k <= COS_ENTRIES; k++) cos_table[k] = cosine_at(k);
    end

    // Watch both channels on every edge.
    always @(posedge i_clk) begin
        t_out_item e;
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) begin
                for (int c = 0; c < NCOMP; c++) begin
                    cur_pose[s][c]  = 0;
                    from_pose[s][c] = 0;
                    goal_pose[s][c] = 0;
                end
                frames_done[s]  = 0;
                frames_total[s] = 0;
                in_motion[s]    = 0;
            end
            expected_poses.delete();
            o_fail_count   = 0;
            o_results_seen = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                o_results_seen++;
                if (expected_poses.size() == 0) begin
                    $error("unexpected output item for bank %0d joint %0d",
                           i_out.out_bank, i_out.out_joint);
                    o_fail_count++;
                end else begin
                    e = expected_poses.pop_front();
                    compare_field("out_bank", e.out_bank, i_out.out_bank);
                    compare_field("out_joint", e.out_joint, i_out.out_joint);
                    compare_field("ang_x", e.ang_x, i_out.ang_x);
                    compare_field("ang_y", e.ang_y, i_out.ang_y);
                    compare_field("ang_z", e.ang_z, i_out.ang_z);
                    compare_field("pos_x", e.pos_x, i_out.pos_x);
                    compare_field("pos_y", e.pos_y, i_out.pos_y);
                    compare_field("pos_z", e.pos_z, i_out.pos_z);
                    compare_field("moving", e.moving, i_out.moving);
                    compare_field("last", e.last, i_out.last);
                end
            end
            if (i_in_valid && i_in_ready) predict_item(i_in);
        end
        o_pending = expected_poses.size();
    end

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_results_seen = 0;
    end

endmodule

/* dv/cosine_eased_pose_tweener_test.sv */
// Testbench top for the pose tweener: drives start and tick items and gives the verdict.
`timescale 1ns / 1ps

module cosine_eased_pose_tweener_test;
    import cept_pkg::*;

    localparam int BANKS       = 3;
    localparam int JOINTS      = 10;
    localparam int COS_ENTRIES = 256;
    localparam int RANDOM_ITEMS = 150;
    localparam int STALL_LIMIT  = 20000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out;
    int        fail_count;
    int        pending;
    int        results_seen;
    int        idle_cycles;
    int        items_sent;
    bit        timed_out;

    cosine_eased_pose_tweener #(
        .BANKS(BANKS), .JOINTS(JOINTS), .COS_ENTRIES(COS_ENTRIES)
    ) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out(o_out)
    );

    cept_pose_checker #(
        .BANKS(BANKS), .JOINTS(JOINTS), .COS_ENTRIES(COS_ENTRIES)
    ) checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready), .i_in(i_in),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready), .i_out(o_out),
        .o_fail_count(fail_count), .o_pending(pending), .o_results_seen(results_seen)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // Receiver stalls: alternates between a free-running stretch and a random pattern.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if ((results_seen / 64) % 3 == 0) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Watchdog on cycles with no accepted item.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Random 32-bit value, biased toward the extremes.
    function automatic logic [31:0] any_word();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return $urandom_range(0, 20) << 16;
            default: return $urandom;
        endcase
    endfunction

    // Short durations so moves finish often; a few long or zero ones.
    function automatic logic [15:0] any_frames();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom);
            default: return 16'($urandom_range(1, 8));
        endcase
    endfunction

    // Offer one item and hold it until it is accepted; valid stays up for the next one.
    task automatic send_item(input t_in_item it);
        i_in       <= it;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_start(input int b, input int j, input logic [31:0] v,
                              input logic [15:0] frames);
        t_in_item it;
        it.req_type     = REQ_START;
        it.bank         = 2'(b);
        it.joint        = 4'(j);
        it.target_ang_x = v;
        it.target_ang_y = ~v;
        it.target_ang_z = any_word();
        it.target_pos_x = any_word();
        it.target_pos_y = any_word();
        it.target_pos_z = any_word();
        it.move_frames  = frames;
        send_item(it);
    endtask

    task automatic send_tick(input int b);
        t_in_item it;
        it          = '0;
        it.req_type = REQ_TICK;
        it.bank     = 2'(b);
        it.joint    = 4'($urandom);
        it.move_frames = 16'($urandom);
        send_item(it);
    endtask

    // Drop valid and wait until every predicted result has been taken.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 && !timed_out) @(posedge i_clk);
    endtask

    initial begin
        t_in_item it;
        int       burst;
        int       gap;
        timed_out   = 0;
        items_sent  = 0;
        idle_cycles = 0;
        i_in_valid  = 1'b0;
        i_out_ready = 1'b0;
        i_in        = '0;
        i_rst_n     = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        fork
            begin
                // Directed: extremes, zero duration, long move, restart, bad bank and joint.
                send_tick(0);
                send_start(0, 0, 32'h7FFF_FFFF, 16'd4);
                send_start(0, 9, 32'h8000_0000, 16'd0);
                send_start(1, 5, 32'hFFFF_FFFF, 16'hFFFF);
                send_start(2, 3, 32'h0001_0000, 16'd1);
                send_tick(0);
                send_tick(0);
                send_start(0, 0, 32'h8000_0000, 16'd3);
                send_tick(0);
                send_tick(1);
                send_tick(2);
                send_start(3, 2, 32'h1234_5678, 16'd2);
                send_tick(3);
                send_start(1, 15, 32'h5555_AAAA, 16'd2);
                send_start(0, 10, 32'hAAAA_5555, 16'd2);
                send_tick(0);
                send_tick(0);
                send_tick(1);
                wait_drained();

                // Random: mostly well-formed starts and ticks in bursts with gaps.
                for (int n = 0; n < RANDOM_ITEMS; n += burst) begin
                    burst = $urandom_range(1, 12);
                    for (int k = 0; k < burst; k++) begin
                        it = '0;
                        if ($urandom_range(0, 2) == 0) begin
                            it.req_type = REQ_TICK;
                            it.bank     = 2'(($urandom_range(0, 19) == 0) ?
                                             3 : $urandom_range(0, 2));
                            it.joint    = 4'($urandom);
                            it.move_frames = 16'($urandom);
                            send_item(it);
                        end else begin
                            send_start(($urandom_range(0, 19) == 0) ? 3 : $urandom_range(0, 2),
                                       ($urandom_range(0, 14) == 0) ? $urandom_range(10, 15)
                                                                     : $urandom_range(0, 9),
                                       any_word(), any_frames());
                        end
                    end
                    if (n > RANDOM_ITEMS / 2 && n < RANDOM_ITEMS / 2 + 13) begin
                        wait_drained();
                    end else begin
                        gap = $urandom_range(0, 30);
                        if (gap != 0) begin
                            i_in_valid <= 1'b0;
                            repeat (gap) @(posedge i_clk);
                        end
                    end
                end
                wait_drained();
                repeat (400) @(posedge i_clk);
            end
            begin
                while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
                timed_out = 1;
            end
        join_any

        if (timed_out) begin
            $display("Some tests failed");
            $finish;
        end else begin
            $display("Sent %0d items (starts, ticks, out-of-range noise); checked %0d poses.",
                     items_sent, results_seen);
            if (fail_count == 0 && pending == 0) begin
                $display("All tests passed");
            end else begin
                $display("Some tests failed");
            end
            $finish;
        end
    end

endmodule
